>>> design/ptru_pkg.sv
// ----------------------------------------------------------------------------
// ptru_pkg
// Shared types, constants and helpers of the periodic task release unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptru_pkg;

    localparam int TICK_W        = 32;
    localparam int STEP_W        = $clog2(TICK_W);
    localparam int CNT_W16       = 16;
    localparam int MASK_W        = 6;
    localparam int WORD_W        = 36;
    localparam int NUM_WORDS     = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int TASK_CNT_W    = 3;
    localparam int TASK_ID_W     = 3;
    localparam int MAX_TASKS_DEF = 6;

    localparam logic [CNT_W16-1:0]   CNT_MAX        = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_WORD0 = 3'd1;
    localparam logic                 REQ_TICK       = 1'b0;
    localparam logic                 REQ_WAIT       = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [TASK_ID_W-1:0] task_id;
    } t_in;

    typedef struct packed {
        logic [MASK_W-1:0]  release_mask;
        logic               granted;
        logic [CNT_W16-1:0] activation_count;
        logic [CNT_W16-1:0] completion_count;
    } t_out;

    typedef struct packed {
        logic                 has_pred;
        logic [TASK_ID_W-1:0] pred;
        logic [15:0]          phase;
        logic [15:0]          period;
    } t_task_word;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [15:0]       divisor;
    } t_mod_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] rem;
    } t_mod_rsp;

    function automatic logic [CNT_W16-1:0] sat_inc(input logic [CNT_W16-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

>>> design/ptru_mod_unit.sv
// ----------------------------------------------------------------------------
// ptru_mod_unit
// Bit-serial restoring remainder unit: 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle, remainder valid with the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module ptru_mod_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ptru_pkg::t_mod_req  i_req,
    output ptru_pkg::t_mod_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ptru_pkg::STEP_W-1:0]   r_cnt;
    logic [ptru_pkg::TICK_W-1:0]   r_dvd;
    logic [15:0]                   r_div;
    logic [15:0]                   r_rem;
    logic [16:0]                   w_trial;
    logic                          w_ge;
    logic [15:0]                   w_next;

    always_comb begin
        w_trial = {r_rem, r_dvd[ptru_pkg::TICK_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_next  = w_ge ? 16'(w_trial - {1'b0, r_div}) : w_trial[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ptru_pkg::STEP_W'(ptru_pkg::TICK_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ptru_pkg::TICK_W-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, rem: r_rem};

endmodule

`default_nettype wire

>>> design/periodic_task_release_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_release_unit
// Tick-driven release of up to MAX_TASKS periodic tasks with phase,
// period and predecessor, plus per-task wait handling.
// ----------------------------------------------------------------------------
// A tick walks the tasks in use one after another: each task passes the
// states LOAD, RDI, RDP, CHK and FIRE for table reads and checks, and also
// DIV in the shared bit-serial remainder unit when its phase has passed, its
// predecessor allows it and its period is nonzero. A tick closes with a last
// LOAD, which advances the tick count, and DONE; a wait passes WRD, WUPD and
// DONE. The input is not ready while an item is in work; a finished result
// sits in the output register and the next item is taken meanwhile.
`default_nettype none

module periodic_task_release_unit #(
    parameter int MAX_TASKS = ptru_pkg::MAX_TASKS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  ptru_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output ptru_pkg::t_out                    o_out_data,
    input  wire                               i_cfg_we,
    input  wire  [ptru_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [ptru_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_RDI  = 4'd2;
    localparam logic [3:0] S_RDP  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_FIRE = 4'd6;
    localparam logic [3:0] S_WRD  = 4'd7;
    localparam logic [3:0] S_WUPD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]                          r_state;
    logic [3:0]                          n_state;
    logic [ptru_pkg::TASK_CNT_W-1:0]     r_task_count;
    logic [ptru_pkg::WORD_W-1:0]         r_word [MAX_TASKS];
    logic [ptru_pkg::TICK_W-1:0]         r_tick;
    logic [ptru_pkg::CNT_W16-1:0]        r_act  [MAX_TASKS];
    logic [ptru_pkg::CNT_W16-1:0]        r_comp [MAX_TASKS];
    logic [MAX_TASKS-1:0]                r_pending;
    logic [CNT_W-1:0]                    r_idx;
    logic [IDX_W-1:0]                    r_addr;
    logic [ptru_pkg::CNT_W16-1:0]        r_rd_act;
    logic [ptru_pkg::CNT_W16-1:0]        r_rd_comp;
    logic [ptru_pkg::CNT_W16-1:0]        r_act_self;
    logic [ptru_pkg::CNT_W16-1:0]        r_comp_self;
    logic                                r_fire;
    logic                                r_wait_ok;
    logic [ptru_pkg::MASK_W-1:0]         r_mask;
    ptru_pkg::t_out                      r_res;
    ptru_pkg::t_out                      r_out;
    logic                                r_out_valid;

    logic [CNT_W-1:0]                    w_used;
    logic [IDX_W-1:0]                    w_idx;
    ptru_pkg::t_task_word                w_word;
    logic                                w_pred_ok;
    logic                                w_phase_ok;
    logic [ptru_pkg::TICK_W-1:0]         w_since;
    logic                                w_need_div;
    logic                                w_in_xfer;
    logic                                w_out_free;
    logic [ptru_pkg::CFG_IDX_W-1:0]      w_cfg_t;
    logic                                w_cfg_word;
    ptru_pkg::t_mod_req                  w_mod_req;
    ptru_pkg::t_mod_rsp                  w_mod_rsp;

    ptru_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    always_comb begin
        if ({1'b0, r_task_count} > CMP_W'(MAX_TASKS)) begin
            w_used = CNT_W'(MAX_TASKS);
        end else begin
            w_used = CNT_W'(r_task_count);
        end
        w_idx      = r_idx[IDX_W-1:0];
        w_word     = ptru_pkg::t_task_word'(r_word[w_idx]);
        w_pred_ok  = !w_word.has_pred ||
                     (({1'b0, w_word.pred} < CMP_W'(w_used)) && (r_comp_self < r_rd_comp));
        w_phase_ok = r_tick >= ptru_pkg::TICK_W'(w_word.phase);
        w_since    = r_tick - ptru_pkg::TICK_W'(w_word.phase);
        w_need_div = w_pred_ok && w_phase_ok && (w_word.period != '0);
        w_in_xfer  = i_in_valid && o_in_ready;
        w_out_free = !r_out_valid || i_out_ready;
        w_cfg_t    = i_cfg_idx - ptru_pkg::REG_TASK_WORD0;
        w_cfg_word = (i_cfg_idx >= ptru_pkg::REG_TASK_WORD0) &&
                     ({1'b0, i_cfg_idx} < CMP_W'(ptru_pkg::NUM_WORDS + 1)) &&
                     ({1'b0, w_cfg_t} < CMP_W'(MAX_TASKS));
        w_mod_req  = '{start:    (r_state == S_CHK) && w_need_div,
                       dividend: w_since,
                       divisor:  w_word.period};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_in_data.req_type == ptru_pkg::REQ_WAIT) ? S_WRD : S_LOAD;
                end
            end
            S_LOAD: n_state = (r_idx >= w_used) ? S_DONE : S_RDI;
            S_RDI:  n_state = S_RDP;
            S_RDP:  n_state = S_CHK;
            S_CHK:  n_state = w_need_div ? S_DIV : S_FIRE;
            S_DIV:  n_state = w_mod_rsp.done ? S_FIRE : S_DIV;
            S_FIRE: n_state = S_LOAD;
            S_WRD:  n_state = S_WUPD;
            S_WUPD: n_state = S_DONE;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and task state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= '0;
            r_tick       <= '0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_word[i] <= '0;
                r_act[i]  <= '0;
                r_comp[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == ptru_pkg::REG_TASK_COUNT) begin
                    r_task_count <= i_cfg_data[ptru_pkg::TASK_CNT_W-1:0];
                end else if (w_cfg_word) begin
                    r_word[w_cfg_t[IDX_W-1:0]] <= i_cfg_data;
                end
            end
            if (r_state == S_IDLE && w_in_xfer) begin
                r_idx <= '0;
            end
            if (r_state == S_LOAD && r_idx >= w_used) begin
                r_tick <= r_tick + 1'b1;
            end
            if (r_state == S_FIRE) begin
                if (r_fire) begin
                    r_pending[w_idx] <= 1'b1;
                    r_act[w_idx]     <= ptru_pkg::sat_inc(r_act_self);
                end
                r_idx <= CNT_W'(r_idx + 1'b1);
            end
            if (r_state == S_WUPD && r_wait_ok && r_pending[r_addr]) begin
                r_pending[r_addr] <= 1'b0;
                r_comp[r_addr]    <= ptru_pkg::sat_inc(r_rd_comp);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_act  <= r_act[r_addr];
        r_rd_comp <= r_comp[r_addr];
        unique case (r_state)
            S_IDLE: begin
                r_mask    <= '0;
                r_addr    <= i_in_data.task_id[IDX_W-1:0];
                r_wait_ok <= {1'b0, i_in_data.task_id} < CMP_W'(w_used);
            end
            S_LOAD: begin
                r_addr <= w_idx;
                r_res  <= '{release_mask: r_mask, default: '0};
            end
            S_RDI: r_addr <= w_word.pred[IDX_W-1:0];
            S_RDP: begin
                r_act_self  <= r_rd_act;
                r_comp_self <= r_rd_comp;
            end
            S_CHK: r_fire <= w_pred_ok && w_phase_ok && (w_since == '0);
            S_DIV: begin
                if (w_mod_rsp.done) begin
                    r_fire <= (w_mod_rsp.rem == '0);
                end
            end
            S_FIRE: begin
                if (r_fire) begin
                    r_mask <= r_mask | (ptru_pkg::MASK_W'(1) << r_idx);
                end
            end
            S_WRD: begin
            end
            S_WUPD: begin
                if (r_wait_ok) begin
                    r_res <= '{release_mask:     '0,
                               granted:          r_pending[r_addr],
                               activation_count: r_rd_act,
                               completion_count: r_pending[r_addr] ?
                                                 ptru_pkg::sat_inc(r_rd_comp) : r_rd_comp};
                end else begin
                    r_res <= '0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_mod_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_req.start |-> !w_mod_rsp.busy)
        else $error("remainder unit started while busy");

    a_wait_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.granted |-> o_out_data.release_mask == '0)
        else $error("granted wait carries a release mask");

    a_grant_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.granted |-> o_out_data.completion_count != '0)
        else $error("granted wait with zero completion count");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) && (r_idx >= w_used) |=> r_tick == $past(r_tick) + 1'b1)
        else $error("tick count did not advance at end of tick");
`endif

endmodule

`default_nettype wire

>>> test/periodic_task_release_unit_tb.sv
// ----------------------------------------------------------------------------
// periodic_task_release_unit_tb
// Self-checking bench for the periodic task release unit. A scoreboard keeps
// its own copy of the task table, tick count, counters and pending bits and
// predicts the result of every accepted tick or wait. Directed ticks and
// waits are sent first, then random traffic under several task setups with
// random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

class release_tracker;
    localparam int TASKS = ptru_pkg::MAX_TASKS_DEF;

    ptru_pkg::t_task_word                 task_words[TASKS];
    logic [ptru_pkg::TASK_CNT_W-1:0]      task_count;
    logic [ptru_pkg::TICK_W-1:0]          tick_count;
    logic [ptru_pkg::CNT_W16-1:0]         activations[TASKS];
    logic [ptru_pkg::CNT_W16-1:0]         completions[TASKS];
    bit                                   pending[TASKS];
    ptru_pkg::t_out                       awaited[$];
    int mismatches;
    int ticks;
    int waits;
    int grants;
    int releases;

    function new();
        task_count = '0;
        tick_count = '0;
        foreach (task_words[i]) begin
            task_words[i]  = '0;
            activations[i] = '0;
            completions[i] = '0;
            pending[i]     = 1'b0;
        end
        mismatches = 0;
        ticks      = 0;
        waits      = 0;
        grants     = 0;
        releases   = 0;
    endfunction

    function void write_reg(logic [ptru_pkg::CFG_IDX_W-1:0] idx,
                            logic [ptru_pkg::WORD_W-1:0] value);
        int slot;
        slot = int'(idx) - int'(ptru_pkg::REG_TASK_WORD0);
        if (idx == ptru_pkg::REG_TASK_COUNT) begin
            task_count = value[ptru_pkg::TASK_CNT_W-1:0];
        end else if (slot >= 0 && slot < TASKS) begin
            task_words[slot] = value;
        end
    endfunction

    function int tasks_in_use();
        return (int'(task_count) > TASKS) ? TASKS : int'(task_count);
    endfunction

    function bit due_now(int i, int used);
        ptru_pkg::t_task_word w;
        logic [ptru_pkg::TICK_W-1:0] since;
        w = task_words[i];
        if (w.has_pred) begin
            if (int'(w.pred) >= used) return 1'b0;
            if (!(completions[i] < completions[w.pred])) return 1'b0;
        end
        if (tick_count < {16'd0, w.phase}) return 1'b0;
        since = tick_count - {16'd0, w.phase};
        if (w.period == 16'd0) return since == '0;
        return (since % {16'd0, w.period}) == '0;
    endfunction

    // predicted result of one accepted transfer on the input channel
    function void take_request(ptru_pkg::t_in req);
        ptru_pkg::t_out exp;
        bit fire[TASKS];
        int used;
        int t;
        used = tasks_in_use();
        exp  = '0;
        if (req.req_type == ptru_pkg::REQ_TICK) begin
            ticks++;
            for (int i = 0; i < used; i++) fire[i] = due_now(i, used);
            for (int i = 0; i < used; i++) begin
                if (fire[i]) begin
                    pending[i] = 1'b1;
                    if (activations[i] != ptru_pkg::CNT_MAX) activations[i]++;
                    exp.release_mask[i] = 1'b1;
                    releases++;
                end
            end
            tick_count = tick_count + 1;
        end else begin
            waits++;
            t = int'(req.task_id);
            if (t < used) begin
                if (pending[t]) begin
                    pending[t] = 1'b0;
                    if (completions[t] != ptru_pkg::CNT_MAX) completions[t]++;
                    exp.granted = 1'b1;
                    grants++;
                end
                exp.activation_count = activations[t];
                exp.completion_count = completions[t];
            end
        end
        awaited.push_back(exp);
    endfunction

    function void check_result(ptru_pkg::t_out got);
        ptru_pkg::t_out exp;
        if (awaited.size() == 0) begin
            $error("result transfer with nothing expected: %h", got);
            mismatches++;
            return;
        end
        exp = awaited.pop_front();
        if (got.release_mask !== exp.release_mask) begin
            $error("release_mask: expected %0h, got %0h", exp.release_mask, got.release_mask);
            mismatches++;
        end
        if (got.granted !== exp.granted) begin
            $error("granted: expected %0d, got %0d", exp.granted, got.granted);
            mismatches++;
        end
        if (got.activation_count !== exp.activation_count) begin
            $error("activation_count: expected %0d, got %0d",
                   exp.activation_count, got.activation_count);
            mismatches++;
        end
        if (got.completion_count !== exp.completion_count) begin
            $error("completion_count: expected %0d, got %0d",
                   exp.completion_count, got.completion_count);
            mismatches++;
        end
    endfunction
endclass

module periodic_task_release_unit_tb;
    import ptru_pkg::*;

    localparam int     TASKS         = MAX_TASKS_DEF;
    localparam int     RANDOM_ITEMS  = 1330;
    localparam int     RANDOM_SETUPS = 7;
    localparam int     TICK_LATENCY  = 2 + 38 * TASKS;
    localparam longint CYCLE_LIMIT   = 2_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(REG_TASK_WORD0 + NUM_WORDS);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    int             send_idle_pct = 37;
    int             recv_idle_pct = 77;
    longint         cycles        = 0;
    int             setups        = 0;
    t_task_word     setup_words[TASKS];
    release_tracker tracker       = new();

    periodic_task_release_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // transfers seen on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.check_result(o_out_data);
            if (i_in_valid && o_in_ready) tracker.take_request(i_in_data);
        end
    end

    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_tick();
        t_in item;
        item.req_type = REQ_TICK;
        item.task_id  = TASK_ID_W'($urandom_range(0, 7));
        send_item(item);
    endtask

    task automatic send_wait(input int id);
        t_in item;
        item.req_type = REQ_WAIT;
        item.task_id  = TASK_ID_W'(id);
        send_item(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [TASK_CNT_W-1:0] count);
        logic [WORD_W-1:0] junk;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TASK_COUNT;
        i_cfg_data <= WORD_W'(count);
        tracker.write_reg(REG_TASK_COUNT, WORD_W'(count));
        @(posedge i_clk);
        for (int w = 0; w < NUM_WORDS; w++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_TASK_WORD0 + CFG_IDX_W'(w);
            i_cfg_data <= setup_words[w];
            tracker.write_reg(REG_TASK_WORD0 + CFG_IDX_W'(w), setup_words[w]);
            @(posedge i_clk);
        end
        // index past the register list, must be ignored
        junk       = WORD_W'({$urandom, $urandom});
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_UNUSED;
        i_cfg_data <= junk;
        tracker.write_reg(REG_UNUSED, junk);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    initial begin
        logic [TASK_CNT_W-1:0] counts[RANDOM_SETUPS];
        int used;
        int id;
        int off;
        int n;
        int r;
        bit found;
        counts = '{3'd6, 3'd1, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: no task in use
        send_tick();
        send_wait(0);
        send_wait(5);
        wait_drained();

        setup_words[0] = '{has_pred: 1'b0, pred: 3'd0, phase: 16'd0, period: 16'd1};
        setup_words[1] = '{has_pred: 1'b1, pred: 3'd0, phase: 16'd3, period: 16'd2};
        setup_words[2] = '{has_pred: 1'b0, pred: 3'd0, phase: 16'd4, period: 16'd0};
        setup_words[3] = '{has_pred: 1'b1, pred: 3'd3, phase: 16'd0, period: 16'd1};
        setup_words[4] = '1;
        setup_words[5] = '{has_pred: 1'b0, pred: 3'd7, phase: 16'hFFFF, period: 16'hFFFF};
        load_setup(3'd6);

        // release while pending, precedence, one-shot task, waits out of range
        send_tick();
        send_wait(0);
        send_wait(0);
        send_tick();
        send_tick();
        send_tick();
        send_wait(1);
        send_wait(2);
        send_wait(2);
        send_wait(3);
        send_wait(4);
        send_wait(5);
        send_wait(6);
        send_wait(7);
        send_tick();
        send_wait(0);
        send_tick();
        send_tick();
        send_wait(1);
        send_wait(0);
        wait_drained();

        n = 0;
        for (int s = 0; s < RANDOM_SETUPS; s++) begin
            for (int w = 0; w < TASKS; w++) begin
                case ($urandom_range(0, 9))
                    0:       setup_words[w].period = 16'd0;
                    1:       setup_words[w].period = 16'($urandom);
                    2:       setup_words[w].period = 16'hFFFF;
                    default: setup_words[w].period = 16'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 9))
                    0:       setup_words[w].phase = 16'($urandom);
                    1:       setup_words[w].phase = 16'hFFFF;
                    2, 3:    setup_words[w].phase = tracker.tick_count[15:0]
                                                    + 16'($urandom_range(0, 12));
                    default: setup_words[w].phase = 16'($urandom_range(0, 8));
                endcase
                if (setup_words[w].period == 16'd0 && $urandom_range(0, 3) != 0) begin
                    setup_words[w].phase = tracker.tick_count[15:0]
                                           + 16'($urandom_range(0, 15));
                end
                setup_words[w].has_pred = ($urandom_range(0, 9) < 4);
                if ($urandom_range(0, 4) == 0 || counts[s] == 0) begin
                    setup_words[w].pred = 3'($urandom_range(0, 7));
                end else begin
                    setup_words[w].pred = 3'($urandom_range(0,
                        (int'(counts[s]) > TASKS ? TASKS : int'(counts[s])) - 1));
                end
            end
            load_setup(counts[s]);

            for (int k = 0; k < RANDOM_ITEMS / RANDOM_SETUPS; k++) begin
                if (n < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 37;
                    recv_idle_pct = 77;
                end else if (n < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 77;
                    recv_idle_pct = 37;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                used = tracker.tasks_in_use();
                r    = $urandom_range(0, 99);
                if (r < 45) begin
                    send_tick();
                end else if (r < 90 && used > 0) begin
                    id = $urandom_range(0, used - 1);
                    // mostly aim at a task with a release waiting
                    if ($urandom_range(0, 2) != 0) begin
                        off   = $urandom_range(0, used - 1);
                        found = 1'b0;
                        for (int c = 0; c < used; c++) begin
                            if (!found && tracker.pending[(off + c) % used]) begin
                                id    = (off + c) % used;
                                found = 1'b1;
                            end
                        end
                    end
                    send_wait(id);
                end else begin
                    send_wait($urandom_range(0, 7));
                end
                n++;
                if ($urandom_range(0, 99) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (TICK_LATENCY) @(posedge i_clk);
        if (tracker.awaited.size() != 0) begin
            $error("%0d expected results never arrived", tracker.awaited.size());
            tracker.mismatches++;
        end
        $display("covered %0d ticks and %0d waits over %0d task setups",
                 tracker.ticks, tracker.waits, setups);
        $display("%0d task releases and %0d granted waits, %0d mismatches",
                 tracker.releases, tracker.grants, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
